// ===== sv/anbs_pkg.sv =====
package anbs_pkg;

	// Largest NAL unit the byte index has to describe; the index saturates one below it,
	// and never above the 16-bit field.
	localparam int unsigned MaxNalBytes = 65536;
	localparam int unsigned IdxLimitInt = ((MaxNalBytes - 1) > 65535) ? 65535 : (MaxNalBytes - 1);
	localparam logic [15:0] IdxLimit    = 16'(IdxLimitInt);

	// One input byte releases at most four held bytes plus one more at end of stream.
	localparam int unsigned MaxEmit   = 5;
	localparam int unsigned FifoDepth = 16;

	localparam logic [7:0] ByteZero    = 8'h00;
	localparam logic [7:0] ByteOne     = 8'h01;
	localparam logic [2:0] StartLen3   = 3'd3;
	localparam logic [2:0] StartLen4   = 3'd4;
	localparam logic [7:0] HdrTypeMask = 8'h1f;
	localparam logic [7:0] HdrRefMask  = 8'h60;

	typedef struct packed {
		logic [7:0]  nal_byte;
		logic        first_of_nal;
		logic        last_of_nal;
		logic [2:0]  start_code_length;
		logic [4:0]  unit_type;
		logic [1:0]  reference_idc;
		logic [15:0] byte_index;
	} nal_item_t;

endpackage

// ===== sv/anbs_byte_if.sv =====
interface anbs_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_stream;

	modport source (output valid, output data_byte, output end_of_stream, input ready);
	modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// ===== sv/anbs_nal_if.sv =====
interface anbs_nal_if;
	logic        valid;
	logic        ready;
	logic [7:0]  nal_byte;
	logic        first_of_nal;
	logic        last_of_nal;
	logic [2:0]  start_code_length;
	logic [4:0]  unit_type;
	logic [1:0]  reference_idc;
	logic [15:0] byte_index;

	modport source (output valid, output nal_byte, output first_of_nal, output last_of_nal,
		output start_code_length, output unit_type, output reference_idc, output byte_index,
		input ready);
	modport sink (input valid, input nal_byte, input first_of_nal, input last_of_nal,
		input start_code_length, input unit_type, input reference_idc, input byte_index,
		output ready);
endinterface

// ===== sv/annexb_nal_unit_splitter_unit.sv =====
// Annex B NAL unit splitter. The block takes an H.264 Annex B byte stream, one byte per
// transaction on the stream channel, and gives out the payload bytes of each NAL unit, one byte
// per transaction on the nal channel, marked with first and last flags, the length of the start
// code that opened the unit (3 or 4), the type and reference priority from the header byte and
// a byte index that saturates at 65535. Bytes before the first start code are dropped, and zeros
// beyond the three that form a four-byte start code belong to the preceding unit. A byte flagged
// end_of_stream is processed, the held bytes are flushed as the tail of the last unit, and the
// block then starts afresh on the next byte. The stream channel takes one byte every cycle when
// not stalled; the results of a byte enter the result queue at the clock edge after its
// transaction and can be taken in the cycle that follows. Because the last byte of a unit is
// only known once the next start code or the end of stream arrives, up to four bytes are held
// back and one input byte may release up to five results at once. These go into a result queue
// of FIFO_DEPTH entries that drains one result per cycle while the nal channel is ready, and
// the stream channel stalls while more than FIFO_DEPTH - 10 results are queued.
module annexb_nal_unit_splitter_unit
	import anbs_pkg::*;
#(
	parameter int unsigned FIFO_DEPTH = FifoDepth
) (
	input logic           clk,
	input logic           arst_n,
	anbs_byte_if.sink     stream,
	anbs_nal_if.source    nal
);

	localparam int unsigned AW         = $clog2(FIFO_DEPTH);
	localparam int unsigned CW         = $clog2(FIFO_DEPTH + 1);
	localparam int unsigned ReadyLimit = FIFO_DEPTH - 2 * MaxEmit;

	// Input register.
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       eos_s1;

	// Splitter state. long_q set means the current unit was opened by a four-byte start code.
	logic       inside_q;
	logic       long_q;
	logic [7:0] header_q;
	logic [15:0] pc_q;
	logic [2:0] hcnt_q;
	logic [7:0] held_q [4];

	// Next state before the end-of-stream reset is applied.
	logic       inside_n;
	logic       long_n;
	logic [7:0] header_n;
	logic [15:0] pc_n;
	logic [2:0] hcnt_n;
	logic [7:0] held_n [4];

	logic [2:0] trail_z;
	logic [2:0] n_main;
	logic       main_last;
	logic       startcode;
	logic [2:0] n_total;
	nal_item_t  item_c [MaxEmit];

	// Result queue.
	nal_item_t      fifo_q [FIFO_DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;
	logic [2:0]     push;
	logic           pop;
	nal_item_t      head;

	function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p, input logic [2:0] k);
		logic [AW:0] s;
		s = {1'b0, p} + (AW + 1)'(k);
		if (s >= (AW + 1)'(FIFO_DEPTH)) begin
			s = s - (AW + 1)'(FIFO_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	// Input side: a byte is taken whenever the queue has room for two bytes' worth of results,
	// one for the byte already in the input register and one for the new byte.
	assign stream.ready = (cnt_q <= CW'(ReadyLimit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= stream.valid & stream.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			data_s1 <= stream.data_byte;
			eos_s1  <= stream.end_of_stream;
		end
	end

	// Count the run of zeros at the tail of the held bytes.
	always_comb begin : p_trail
		logic run;
		run     = 1'b1;
		trail_z = 3'd0;
		for (int i = 3; i >= 0; i--) begin
			if ((3'(i) < hcnt_q) && run) begin
				if (held_q[i] == ByteZero) begin
					trail_z = trail_z + 3'd1;
				end else begin
					run = 1'b0;
				end
			end
		end
	end

	// One step of the splitter for the byte in the input register.
	always_comb begin : p_step
		logic        is_zero;
		logic        is_one;
		logic [16:0] pc_sum;
		is_zero   = (data_s1 == ByteZero);
		is_one    = (data_s1 == ByteOne);
		inside_n  = inside_q;
		long_n    = long_q;
		header_n  = header_q;
		hcnt_n    = hcnt_q;
		held_n    = held_q;
		n_main    = 3'd0;
		main_last = 1'b0;
		startcode = 1'b0;
		if (!inside_q) begin
			// Searching for the first start code: only the zero run matters.
			if (is_one && (hcnt_q >= 3'd2)) begin
				inside_n = 1'b1;
				long_n   = (hcnt_q >= 3'd3);
				hcnt_n   = 3'd0;
				header_n = ByteZero;
			end else if (is_zero) begin
				if (hcnt_q < 3'd3) begin
					hcnt_n = hcnt_q + 3'd1;
				end
			end else begin
				hcnt_n = 3'd0;
			end
		end else if (is_one && (trail_z >= 3'd2)) begin
			// A start code closes the unit; at most three of the trailing zeros belong to it.
			startcode = 1'b1;
			n_main    = hcnt_q - ((trail_z > 3'd3) ? 3'd3 : trail_z);
			main_last = 1'b1;
			long_n    = (trail_z >= 3'd3);
			hcnt_n    = 3'd0;
			header_n  = ByteZero;
		end else begin
			if ((hcnt_q == 3'd0) && (pc_q == 16'd0)) begin
				header_n = data_s1;
			end
			if (!is_zero) begin
				// A non-zero byte cannot end a start code, so everything held may go.
				n_main    = hcnt_q;
				held_n[0] = data_s1;
				hcnt_n    = 3'd1;
			end else if (hcnt_q == 3'd4) begin
				n_main    = 3'd1;
				held_n[0] = held_q[1];
				held_n[1] = held_q[2];
				held_n[2] = held_q[3];
				held_n[3] = data_s1;
				hcnt_n    = 3'd4;
			end else begin
				held_n[hcnt_q[1:0]] = data_s1;
				hcnt_n              = hcnt_q + 3'd1;
			end
		end

		// Byte index after this step, saturating.
		pc_sum = {1'b0, pc_q} + 17'(n_main);
		if (!inside_q || startcode) begin
			pc_n = inside_n ? 16'd0 : pc_q;
			if (startcode) begin
				pc_n = 16'd0;
			end
		end else begin
			pc_n = (pc_sum >= {1'b0, IdxLimit}) ? IdxLimit : pc_sum[15:0];
		end

		// At end of stream the bytes still held are flushed behind those released above.
		n_total = n_main + ((eos_s1 && inside_n) ? hcnt_n : 3'd0);
	end

	// Build the results of this step, in order.
	always_comb begin : p_items
		logic [2:0]  j;
		logic [16:0] idx;
		logic [7:0]  hdr;
		hdr = startcode ? header_q : header_n;
		for (int k = 0; k < MaxEmit; k++) begin
			j   = 3'(k) - n_main;
			idx = {1'b0, pc_q} + 17'(k);
			if (3'(k) < n_main) begin
				item_c[k].nal_byte    = held_q[k % 4];
				item_c[k].last_of_nal = main_last && (3'(k) == n_main - 3'd1);
			end else begin
				item_c[k].nal_byte    = held_n[j[1:0]];
				item_c[k].last_of_nal = (3'(k) == n_total - 3'd1);
			end
			item_c[k].first_of_nal      = (pc_q == 16'd0) && (k == 0);
			item_c[k].start_code_length = long_q ? StartLen4 : StartLen3;
			item_c[k].unit_type         = 5'(hdr & HdrTypeMask);
			item_c[k].reference_idc     = 2'((hdr & HdrRefMask) >> 5);
			item_c[k].byte_index        = (idx >= {1'b0, IdxLimit}) ? IdxLimit : idx[15:0];
		end
	end

	// State update; end of stream returns everything to its reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			long_q   <= 1'b0;
			header_q <= '0;
			pc_q     <= '0;
			hcnt_q   <= '0;
			for (int i = 0; i < 4; i++) begin
				held_q[i] <= '0;
			end
		end else if (valid_s1) begin
			if (eos_s1) begin
				inside_q <= 1'b0;
				long_q   <= 1'b0;
				header_q <= '0;
				pc_q     <= '0;
				hcnt_q   <= '0;
				for (int i = 0; i < 4; i++) begin
					held_q[i] <= '0;
				end
			end else begin
				inside_q <= inside_n;
				long_q   <= long_n;
				header_q <= header_n;
				pc_q     <= pc_n;
				hcnt_q   <= hcnt_n;
				held_q   <= held_n;
			end
		end
	end

	// Result queue: up to five writes a cycle at consecutive places, one read.
	assign push = valid_s1 ? n_total : 3'd0;
	assign pop  = nal.valid & nal.ready;

	always_ff @(posedge clk) begin
		for (int k = 0; k < MaxEmit; k++) begin
			if (3'(k) < push) begin
				fifo_q[ptr_add(wr_q, 3'(k))] <= item_c[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= ptr_add(wr_q, push);
			rd_q  <= ptr_add(rd_q, {2'b00, pop});
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	assign head                  = fifo_q[rd_q];
	assign nal.valid             = (cnt_q != '0);
	assign nal.nal_byte          = head.nal_byte;
	assign nal.first_of_nal      = head.first_of_nal;
	assign nal.last_of_nal       = head.last_of_nal;
	assign nal.start_code_length = head.start_code_length;
	assign nal.unit_type         = head.unit_type;
	assign nal.reference_idc     = head.reference_idc;
	assign nal.byte_index        = head.byte_index;

	// The queue never overflows.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(FIFO_DEPTH))
		else $error("result queue overflow");

	// While searching for the first start code no byte is released.
	a_search_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !inside_q) |-> (n_total == 3'd0))
		else $error("result released before the first start code");

	// A header byte always carries index zero.
	a_first_index: assert property (@(posedge clk) disable iff (!arst_n)
		(nal.valid && nal.first_of_nal) |-> (nal.byte_index == 16'd0))
		else $error("header byte with non-zero index");

	// The hold window never grows beyond four bytes.
	a_hold_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hcnt_q <= 3'd4)
		else $error("hold window overrun");

endmodule
